// ----- hw/rtl/hslp_pkg.sv -----
// ----------------------------------------------------------------------------
// hslp_pkg
// Shared types and constants of the hex sensor line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hslp_pkg;

	localparam int LINE_LIMIT  = 256;
	localparam int FIELD_COUNT = 10;

	// line position saturates at the limit, so it must hold the limit itself
	localparam int POS_W   = $clog2(LINE_LIMIT + 1);
	localparam int PAY_W   = $clog2(FIELD_COUNT * 4 + 1);
	localparam int GROUP_W = PAY_W - 2;

	localparam int TQ_DEPTH = 4;
	localparam int TQ_AW    = $clog2(TQ_DEPTH);
	localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_COLON   = 8'h3a;

	localparam logic [1:0] SLOT_LAST = 2'd3;

	typedef enum logic [1:0] {
		PH_SEEK,
		PH_SKIP,
		PH_GATHER,
		PH_DONE
	} phase_t;

	// one gathered character, already decoded
	typedef struct packed {
		logic [3:0]         nibble;
		logic               bad;
		logic [1:0]         slot;
		logic [GROUP_W-1:0] group;
	} token_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hslp_front.sv -----
// ----------------------------------------------------------------------------
// hslp_front
// Line tracking: finds the colon, skips one byte, decodes non-space payload characters
// and hands each one on as a token with its group and slot.
// ----------------------------------------------------------------------------
`default_nettype none

module hslp_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    byte_valid,
	input  wire logic [7:0]              char_byte,
	output hslp_pkg::token_t             tok,
	output logic                         tok_valid
);

	hslp_pkg::phase_t              phase_q, phase_d;
	logic [hslp_pkg::POS_W-1:0]    pos_q, pos_d;
	logic [hslp_pkg::PAY_W-1:0]    count_q, count_d;

	logic       line_end;
	logic       in_limit;
	logic       is_digit;
	logic       is_lower;
	logic [3:0] nib;

	assign line_end = (char_byte == hslp_pkg::CH_NEWLINE) || (char_byte == hslp_pkg::CH_NUL);
	assign in_limit = pos_q < hslp_pkg::POS_W'(hslp_pkg::LINE_LIMIT);
	assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
	assign is_lower = (char_byte >= 8'h61) && (char_byte <= 8'h66);

	always_comb begin
		if (is_digit) begin
			nib = char_byte[3:0];
		end else if (is_lower) begin
			nib = char_byte[3:0] + 4'd9;
		end else begin
			nib = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hslp_pkg::PH_SEEK;
			pos_q   <= '0;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		count_d    = count_q;
		tok_valid  = 1'b0;
		tok.nibble = nib;
		tok.bad    = !(is_digit || is_lower);
		tok.slot   = count_q[1:0];
		tok.group  = count_q[hslp_pkg::PAY_W-1:2];
		if (byte_valid) begin
			if (line_end) begin
				phase_d = hslp_pkg::PH_SEEK;
				pos_d   = '0;
				count_d = '0;
			end else if (in_limit) begin
				pos_d = pos_q + 1'b1;
				unique case (phase_q)
					hslp_pkg::PH_SEEK: begin
						if (char_byte == hslp_pkg::CH_COLON) begin
							phase_d = hslp_pkg::PH_SKIP;
						end
					end
					hslp_pkg::PH_SKIP: begin
						phase_d = hslp_pkg::PH_GATHER;
					end
					hslp_pkg::PH_GATHER: begin
						if (char_byte != hslp_pkg::CH_SPACE) begin
							tok_valid = 1'b1;
							count_d   = count_q + 1'b1;
							if (tok.slot == hslp_pkg::SLOT_LAST &&
							    tok.group == hslp_pkg::GROUP_W'(hslp_pkg::FIELD_COUNT - 1)) begin
								phase_d = hslp_pkg::PH_DONE;
							end
						end
					end
					hslp_pkg::PH_DONE: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hslp_token_queue.sv -----
// ----------------------------------------------------------------------------
// hslp_token_queue
// Short first-in first-out queue of tokens between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hslp_token_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire hslp_pkg::token_t wr_tok,
	input  wire logic             rd_en,
	output hslp_pkg::token_t      rd_tok,
	output logic                  not_empty,
	output logic                  is_full
);

	hslp_pkg::token_t               mem_q [hslp_pkg::TQ_DEPTH];
	logic [hslp_pkg::TQ_AW-1:0]     wr_ptr_q;
	logic [hslp_pkg::TQ_AW-1:0]     rd_ptr_q;
	logic [hslp_pkg::TQ_CW-1:0]     count_q;

	assign not_empty = count_q != '0;
	assign is_full   = count_q == hslp_pkg::TQ_CW'(hslp_pkg::TQ_DEPTH);
	assign rd_tok    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hslp_back.sv -----
// ----------------------------------------------------------------------------
// hslp_back
// Group assembly: builds each 16-bit sample from four tokens and holds the
// finished word in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hslp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               tok_valid,
	input  wire hslp_pkg::token_t   tok,
	output logic                    tok_pop,
	input  wire logic               pop,
	output logic                    empty,
	output logic [3:0]              channel,
	output logic signed [15:0]      sample_value,
	output logic                    bad_hex,
	output logic                    last_of_line
);

	logic [15:0] word_q, word_d;
	logic        bad_q, bad_d;
	logic        out_valid_q;
	logic        emit;
	logic        out_pop;
	logic [15:0] placed;

	// text order within a group is high nibble then low nibble of each byte
	always_comb begin
		case (tok.slot)
			2'd0:    placed = {8'h00, tok.nibble, 4'h0};
			2'd1:    placed = {12'h000, tok.nibble};
			2'd2:    placed = {tok.nibble, 12'h000};
			default: placed = {4'h0, tok.nibble, 8'h00};
		endcase
	end

	assign word_d  = ((tok.slot == 2'd0) ? 16'h0000 : word_q) | placed;
	assign bad_d   = ((tok.slot == 2'd0) ? 1'b0 : bad_q) | tok.bad;
	assign emit    = (tok.slot == hslp_pkg::SLOT_LAST) && (tok.group != '0);
	assign out_pop = pop && out_valid_q;
	assign tok_pop = tok_valid && (!emit || !out_valid_q || out_pop);
	assign empty   = !out_valid_q;

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			word_q <= word_d;
			bad_q  <= bad_d;
		end
		if (tok_pop && emit) begin
			channel      <= 4'(tok.group - 1'b1);
			sample_value <= bad_d ? 16'sh0000 : signed'(word_d);
			bad_hex      <= bad_d;
			last_of_line <= tok.group == hslp_pkg::GROUP_W'(hslp_pkg::FIELD_COUNT - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok_pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hex_sensor_line_parser.sv -----
// ----------------------------------------------------------------------------
// hex_sensor_line_parser
// Turns a text stream of sensor lines into signed per-channel samples.
// ----------------------------------------------------------------------------
// One character is taken per cycle, back to back, for as long as the token
// queue between the line tracker and the group assembler has room; the
// assembler drains one token per cycle, so full only rises when results are
// left unpopped. Each line is searched for its first colon, the byte after it
// is skipped, and the remaining non-space characters are read as groups of
// four lower-case hex digits, low byte first. The first group (timestamp) is
// dropped; every later group gives one result with its channel, the sample
// (zero when the group held a non-hex character), bad_hex and last_of_line
// on the final channel. A result passes through the token queue and then the
// result register before it shows on the result ports. Newline or NUL ends a
// line; bytes past the line limit are ignored.
`default_nettype none

module hex_sensor_line_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [7:0]         char_byte,
	input  wire logic               pop,
	output logic                    empty,
	output logic [3:0]              channel,
	output logic signed [15:0]      sample_value,
	output logic                    bad_hex,
	output logic                    last_of_line
);

	hslp_pkg::token_t front_tok;
	hslp_pkg::token_t queue_tok;
	logic             front_tok_valid;
	logic             queue_not_empty;
	logic             queue_pop;
	logic             accept;

	assign accept = push && !full;

	hslp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (accept),
		.char_byte  (char_byte),
		.tok        (front_tok),
		.tok_valid  (front_tok_valid)
	);

	hslp_token_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (front_tok_valid),
		.wr_tok    (front_tok),
		.rd_en     (queue_pop),
		.rd_tok    (queue_tok),
		.not_empty (queue_not_empty),
		.is_full   (full)
	);

	hslp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (queue_not_empty),
		.tok          (queue_tok),
		.tok_pop      (queue_pop),
		.pop          (pop),
		.empty        (empty),
		.channel      (channel),
		.sample_value (sample_value),
		.bad_hex      (bad_hex),
		.last_of_line (last_of_line)
	);

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Feeds the sensor line parser with text lines one character word at a time
// and checks every sample word it returns against a software parse of the
// same stream, with random gaps on both sides of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TARGET_CHARS   = 1050;
	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          IDLE_PCT       = 18;
	localparam logic [7:0]  CH_ZERO        = "0";
	localparam logic [7:0]  CH_NINE        = "9";
	localparam logic [7:0]  CH_A_LOW       = "a";
	localparam logic [7:0]  CH_F_LOW       = "f";
	localparam logic [7:0]  CH_A_UP        = "A";

	typedef struct packed {
		logic [3:0]         channel;
		logic signed [15:0] value;
		logic               bad;
		logic               last;
	} sample_t;

	class sample_scoreboard;
		sample_t    expected_q[$];
		int         errors;
		hslp_pkg::phase_t phase;
		int         line_pos;
		int         char_count;
		logic [15:0] group_word;
		logic       group_bad;

		function new();
			errors = 0;
			clear_line();
		endfunction

		function void clear_line();
			phase      = hslp_pkg::PH_SEEK;
			line_pos   = 0;
			char_count = 0;
			group_word = '0;
			group_bad  = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// parse one accepted character word, queue a sample when a group completes
		function void note_char(logic [7:0] c);
			int          pos;
			int          slot;
			int          grp;
			logic [3:0]  nib;
			logic        is_hex;
			sample_t     s;
			if (c == hslp_pkg::CH_NEWLINE || c == hslp_pkg::CH_NUL) begin
				clear_line();
				return;
			end
			pos = line_pos;
			if (line_pos < hslp_pkg::LINE_LIMIT)
				line_pos++;
			if (pos >= hslp_pkg::LINE_LIMIT)
				return;
			case (phase)
				hslp_pkg::PH_SEEK: begin
					if (c == hslp_pkg::CH_COLON)
						phase = hslp_pkg::PH_SKIP;
					return;
				end
				hslp_pkg::PH_SKIP: begin
					phase = hslp_pkg::PH_GATHER;
					return;
				end
				hslp_pkg::PH_DONE: return;
				default: ;
			endcase
			if (c == hslp_pkg::CH_SPACE)
				return;
			slot   = char_count % 4;
			grp    = char_count / 4;
			is_hex = 1'b1;
			nib    = '0;
			if (c >= CH_ZERO && c <= CH_NINE)
				nib = 4'(c - CH_ZERO);
			else if (c >= CH_A_LOW && c <= CH_F_LOW)
				nib = 4'(c - CH_A_LOW + 8'd10);
			else
				is_hex = 1'b0;
			if (!is_hex)
				group_bad = 1'b1;
			else begin
				// first pair is the low byte, high nibble first
				case (slot)
					0: group_word[7:4]   = nib;
					1: group_word[3:0]   = nib;
					2: group_word[15:12] = nib;
					default: group_word[11:8] = nib;
				endcase
			end
			char_count++;
			if (slot != 3)
				return;
			s.value    = group_bad ? 16'sd0 : group_word;
			s.bad      = group_bad;
			group_word = '0;
			group_bad  = 1'b0;
			if (grp + 1 >= hslp_pkg::FIELD_COUNT)
				phase = hslp_pkg::PH_DONE;
			// group zero is the timestamp
			if (grp == 0)
				return;
			s.channel = 4'(grp - 1);
			s.last    = (grp == hslp_pkg::FIELD_COUNT - 1);
			expected_q.push_back(s);
		endfunction

		task flag_mismatch(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [3:0] ch, logic signed [15:0] val, logic bad, logic last);
			sample_t e;
			if (expected_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected word ch=%0d value=%0d", ch, val));
				return;
			end
			e = expected_q.pop_front();
			if (ch !== e.channel)
				flag_mismatch($sformatf("channel %0d, want %0d", ch, e.channel));
			if (val !== e.value)
				flag_mismatch($sformatf("ch %0d value %0d, want %0d", e.channel, val, e.value));
			if (bad !== e.bad)
				flag_mismatch($sformatf("ch %0d bad_hex %0b, want %0b", e.channel, bad, e.bad));
			if (last !== e.last)
				flag_mismatch($sformatf("ch %0d last %0b, want %0b", e.channel, last, e.last));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         char_byte;
	logic               pop;
	logic               empty;
	logic [3:0]         channel;
	logic signed [15:0] sample_value;
	logic               bad_hex;
	logic               last_of_line;

	sample_scoreboard   sb;
	int                 chars_sent;
	int                 quiet_cycles;
	logic               calm;
	int                 hold;

	hex_sensor_line_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_byte    (char_byte),
		.pop          (pop),
		.empty        (empty),
		.channel      (channel),
		.sample_value (sample_value),
		.bad_hex      (bad_hex),
		.last_of_line (last_of_line)
	);

	always #5 clk = ~clk;

	// monitor: both handshakes are sampled at the edge, before any output moves
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_char(char_byte);
			if (pop && !empty)
				sb.check_result(channel, sample_value, bad_hex, last_of_line);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result side: random stalls, now and then a long one to fill the block up
	initial begin
		pop  <= 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (!calm && hold == 0 && $urandom_range(0, 199) == 0)
				hold = $urandom_range(10, 40);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else
				pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic logic [7:0] hex_char(int unsigned n);
		return (n < 10) ? CH_ZERO + 8'(n) : CH_A_LOW + 8'(n - 10);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == hslp_pkg::CH_NEWLINE || b == hslp_pkg::CH_NUL);
		return b;
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do
			b = plain_byte();
		while (b == hslp_pkg::CH_COLON);
		return b;
	endfunction

	function automatic logic [7:0] line_end();
		return ($urandom_range(0, 3) == 0) ? hslp_pkg::CH_NUL : hslp_pkg::CH_NEWLINE;
	endfunction

	task automatic send_char(logic [7:0] c);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		char_byte <= c;
		do
			@(posedge clk);
		while (full);
		chars_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_prefix(int n);
		for (int i = 0; i < n; i++)
			send_char(text_byte());
	endtask

	// hex groups with the odd space and the odd corrupted digit
	task automatic send_groups(int groups, int bad_pct, int space_pct);
		for (int g = 0; g < groups; g++) begin
			for (int d = 0; d < 4; d++) begin
				if ($urandom_range(0, 99) < space_pct)
					send_char(hslp_pkg::CH_SPACE);
				if ($urandom_range(0, 99) < bad_pct)
					send_char($urandom_range(0, 1) ? CH_A_UP + 8'($urandom_range(0, 5))
						: plain_byte());
				else
					send_char(hex_char($urandom_range(0, 15)));
			end
		end
	endtask

	task automatic send_line(int line_no);
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (line_no == 2) begin
			// no colon inside the limit: the late colon must be ignored
			send_prefix(hslp_pkg::LINE_LIMIT);
			send_char(hslp_pkg::CH_COLON);
			send_char(plain_byte());
			send_groups(hslp_pkg::FIELD_COUNT, 0, 0);
		end else if (line_no == 5) begin
			// colon near the limit, payload cut off part way
			send_prefix($urandom_range(hslp_pkg::LINE_LIMIT - 30, hslp_pkg::LINE_LIMIT - 1));
			send_char(hslp_pkg::CH_COLON);
			send_char(plain_byte());
			send_groups(hslp_pkg::FIELD_COUNT, 4, 6);
		end else if (r < 60) begin
			send_prefix($urandom_range(0, 3));
			send_char(hslp_pkg::CH_COLON);
			send_char(plain_byte());
			n = ($urandom_range(0, 99) < 85) ? hslp_pkg::FIELD_COUNT
				: $urandom_range(hslp_pkg::FIELD_COUNT + 1, hslp_pkg::FIELD_COUNT + 3);
			send_groups(n, 4, 6);
			if ($urandom_range(0, 3) == 0)
				send_prefix($urandom_range(1, 4));
		end else if (r < 75) begin
			send_prefix($urandom_range(0, 3));
			send_char(hslp_pkg::CH_COLON);
			send_char(plain_byte());
			send_groups($urandom_range(0, hslp_pkg::FIELD_COUNT - 1), 4, 6);
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++)
				send_char(hex_char($urandom_range(0, 15)));
		end else if (r < 85) begin
			n = $urandom_range(1, 24);
			for (int i = 0; i < n; i++)
				send_char(8'($urandom_range(0, 255)));
		end else if (r < 92)
			send_prefix($urandom_range(1, 20));
		else begin
			send_char(hslp_pkg::CH_COLON);
			if ($urandom_range(0, 1)) begin
				send_char(plain_byte());
				send_groups(hslp_pkg::FIELD_COUNT, 50, 10);
			end
		end
		send_char(line_end());
	endtask

	initial begin
		int line_no;
		sb           = new();
		chars_sent   = 0;
		quiet_cycles = 0;
		calm         = 1'b0;
		arst_n       <= 1'b0;
		push         <= 1'b0;
		char_byte    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the sample, bad groups, colon in payload, spaces, extra group
		send_text("ab:x0000 0080ff7fffff abcd0001 00A0g:007f00 9876 1234\n");
		// colon as the skipped byte, then a partial group dropped by NUL
		send_text("q::1234ab");
		send_char(hslp_pkg::CH_NUL);
		// line ending right after its colon
		send_text(":\n");
		send_text(": 0000c3e1\n");

		line_no = 0;
		while (chars_sent < TARGET_CHARS) begin
			if (line_no == 4) begin
				push <= 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
			end
			calm = (line_no >= 6 && line_no < 10);
			send_line(line_no);
			line_no++;
		end
		calm = 1'b0;
		push <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
